// ----- rtl/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants and register codes for the byte pattern search block.
// ----------------------------------------------------------------------------
package bps_pkg;

    // default sizing
    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_POSITION_BITS     = 32;

    // fixed field widths
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int LEN_W         = 5;
    localparam int START_W       = 32;
    localparam int OFFSET_W      = 32;
    localparam int PAT_REG_BYTES = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 2'd3;

    // reset value of the pattern length register
    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

endpackage

// ----- rtl/bps_cfg.sv -----
// ----------------------------------------------------------------------------
// bps_cfg
// Configuration registers, the registered length-aligned pattern, and the
// length checks and match threshold derived from them.
// ----------------------------------------------------------------------------
module bps_cfg #(
    parameter int MAX_PATTERN_BYTES = bps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int CMP_W             = 33
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [MAX_PATTERN_BYTES*8-1:0]  o_pat_aligned,
    output logic [MAX_PATTERN_BYTES-1:0]    o_pat_mask,
    output logic                            o_len_ok,
    output logic [bps_pkg::LEN_W-1:0]       o_len_m1,
    output logic [CMP_W-1:0]                o_thresh
);
    import bps_pkg::*;

    logic [CFG_DATA_W-1:0]           r_pat_low;
    logic [CFG_DATA_W-1:0]           r_pat_high;
    logic [LEN_W-1:0]                r_len;
    logic [START_W-1:0]              r_start;

    logic [MAX_PATTERN_BYTES*8-1:0]  r_pat_aligned;
    logic [MAX_PATTERN_BYTES-1:0]    r_pat_mask;

    logic [MAX_PATTERN_BYTES*8-1:0]  n_pat_aligned;
    logic [MAX_PATTERN_BYTES-1:0]    n_pat_mask;
    logic [PAT_REG_BYTES*8-1:0]      pat_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_len      <= LEN_RESET;
            r_start    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                REG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                REG_PATTERN_LENGTH: r_len      <= i_cfg_data[LEN_W-1:0];
                REG_START_OFFSET:   r_start    <= i_cfg_data[START_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_all = {r_pat_high, r_pat_low};

    // window entry i lines up with pattern byte len-1-i
    always_comb begin
        logic [LEN_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            idx = LEN_W'(int'(r_len) - 1 - i);
            n_pat_mask[i]         = (i < int'(r_len));
            n_pat_aligned[i*8 +: 8] = 8'h00;
            if ((i < int'(r_len)) && !idx[LEN_W-1]) begin
                n_pat_aligned[i*8 +: 8] = pat_all[{idx[LEN_W-2:0], 3'b000} +: 8];
            end
        end
    end

    // compare is one stage behind the input, so a register here is in time
    always_ff @(posedge i_clk) begin
        r_pat_aligned <= n_pat_aligned;
        r_pat_mask    <= n_pat_mask;
    end

    assign o_pat_aligned = r_pat_aligned;
    assign o_pat_mask    = r_pat_mask;

    // used at the input transfer itself, straight from the registers
    assign o_len_ok = (r_len != '0) && (int'(r_len) <= MAX_PATTERN_BYTES);
    assign o_len_m1 = r_len - LEN_W'(1);
    assign o_thresh = CMP_W'(r_start) + CMP_W'(r_len) - CMP_W'(1);

endmodule

// ----- rtl/bps_window.sv -----
// ----------------------------------------------------------------------------
// bps_window
// Shift line of the most recent bytes and its parallel compare against the
// aligned pattern.
// ----------------------------------------------------------------------------
module bps_window #(
    parameter int MAX_PATTERN_BYTES = bps_pkg::DEF_MAX_PATTERN_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_shift,
    input  logic [7:0]                      i_byte,
    input  logic [MAX_PATTERN_BYTES*8-1:0]  i_pat_aligned,
    input  logic [MAX_PATTERN_BYTES-1:0]    i_pat_mask,
    output logic                            o_match
);
    import bps_pkg::*;

    logic [7:0]                   r_window [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] byte_ok;

    // entry 0 is the newest byte
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_window[0] <= i_byte;
            for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
                r_window[i] <= r_window[i-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            byte_ok[i] = !i_pat_mask[i] || (r_window[i] == i_pat_aligned[i*8 +: 8]);
        end
    end

    assign o_match = &byte_ok;

endmodule

// ----- rtl/byte_pattern_search.sv -----
// ----------------------------------------------------------------------------
// byte_pattern_search
// Streaming first-occurrence search of a 1 to 16 byte pattern in a buffer.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per cycle on the slave stream, tlast on the
// final byte, and gives one verdict per buffer on the master stream: found
// with the offset of the first matching byte on the byte that completes the
// first match at or after start_offset, or not found (offset zero) on the
// last byte when nothing matched. Throughput is one byte per clock while the
// master side keeps up. A byte transfer loads stage 1 (window shift, position
// count); when stage 1 advances, the parallel window compare loads the
// verdict into the output register, from which it transfers to the master
// stream. A stalled master side holds the output register and then stage 1,
// which drops s_axis_tready. Length and start offset feed the eligibility
// check directly, and the length-aligned pattern is rebuilt in a register
// from the written values, in time for the compare of a byte transferred
// right after the write. The configuration port is always ready.
module byte_pattern_search #(
    parameter int MAX_PATTERN_BYTES = bps_pkg::DEF_MAX_PATTERN_BYTES,
    parameter int POSITION_BITS     = bps_pkg::DEF_POSITION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tlast,   // last_byte
    // master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [31:0] match_offset
    output logic                           m_axis_tuser,   // [0] found
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bps_pkg::*;

    // compare width covers both the position and start offset plus len
    localparam int CMP_W = ((POSITION_BITS > START_W) ? POSITION_BITS : START_W) + 1;

    // derived configuration
    logic [MAX_PATTERN_BYTES*8-1:0] pat_aligned;
    logic [MAX_PATTERN_BYTES-1:0]   pat_mask;
    logic                           len_ok;
    logic [LEN_W-1:0]               len_m1;
    logic [CMP_W-1:0]               thresh;

    // input stage
    logic                           in_xfer;
    logic [POSITION_BITS-1:0]       r_pos;
    logic                           pos_sat;
    logic                           r_s1_valid;
    logic                           r_s1_last;
    logic                           r_s1_elig;
    logic [OFFSET_W-1:0]            r_s1_off;
    logic [CMP_W-1:0]               n_s1_first;

    // compare / verdict stage
    logic                           window_match;
    logic                           s1_adv;
    logic                           hit;
    logic                           emit;
    logic                           r_verdict;

    // output register
    logic                           r_out_valid;
    logic                           r_out_found;
    logic [OFFSET_W-1:0]            r_out_off;

    assign o_cfg_ready = 1'b1;

    bps_cfg #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
        .CMP_W             (CMP_W)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pat_aligned (pat_aligned),
        .o_pat_mask    (pat_mask),
        .o_len_ok      (len_ok),
        .o_len_m1      (len_m1),
        .o_thresh      (thresh)
    );

    // the window shifts on every transfer, so entry 0 is the byte in stage 1
    bps_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .i_clk         (i_clk),
        .i_shift       (in_xfer),
        .i_byte        (s_axis_tdata),
        .i_pat_aligned (pat_aligned),
        .i_pat_mask    (pat_mask),
        .o_match       (window_match)
    );

    // stage 1 moves on when the output register is free or being drained
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // a byte at the saturated position is never searched
    assign pos_sat    = (r_pos == {POSITION_BITS{1'b1}});
    assign n_s1_first = CMP_W'(r_pos) - CMP_W'(len_m1);

    // position counter, restarts after the last byte of a buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (in_xfer) begin
            if (s_axis_tlast) begin
                r_pos <= '0;
            end else if (!pos_sat) begin
                r_pos <= r_pos + POSITION_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // eligibility: match start at or past start_offset and fully received
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_last <= s_axis_tlast;
            r_s1_elig <= !pos_sat && len_ok && (CMP_W'(r_pos) >= thresh);
            r_s1_off  <= n_s1_first[OFFSET_W-1:0];
        end
    end

    // first match only; the last byte always closes the buffer
    assign hit  = r_s1_elig && !r_verdict && window_match;
    assign emit = hit || (r_s1_last && !r_verdict);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict <= 1'b0;
        end else if (s1_adv) begin
            r_verdict <= r_s1_last ? 1'b0 : (r_verdict || hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_found <= hit;
            r_out_off   <= hit ? r_s1_off : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = r_out_off;

`ifndef NO_ASSERTIONS
    // input side only stalls behind an occupied stage 1
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid)
        else $error("input stalled with empty stage 1");

    // a found verdict inside a buffer blocks further results
    a_verdict_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && hit && !r_s1_last) |=> r_verdict)
        else $error("verdict flag not set after a match");

    // the last byte always starts a fresh buffer
    a_verdict_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> !r_verdict)
        else $error("verdict flag survived end of buffer");

    // not found results carry a zero offset
    a_nf_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("not found result with nonzero offset");
`endif

endmodule

// ----- tb/byte_pattern_search_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_pattern_search_tb
// Self-checking bench for the streaming byte pattern search block.
// ----------------------------------------------------------------------------
// A plan of byte transfers, register writes and quiet points is built up
// front. A negedge driver feeds it to the slave stream and the config
// channel in bursts with random gaps. A posedge monitor runs its own copy of
// the search on every accepted byte and checks each accepted verdict against
// the oldest predicted one. The result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module byte_pattern_search_tb;
    import bps_pkg::*;

    localparam int PAT_BYTES     = DEF_MAX_PATTERN_BYTES;
    localparam int POS_W         = DEF_POSITION_BITS;
    localparam int RANDOM_BYTES  = 420;
    localparam int QUIET_CYCLES  = 6;        // covers stage 1 and the output register
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 100;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_WRITE,
        OP_QUIET
    } plan_kind_e;

    typedef struct packed {
        plan_kind_e            kind;
        logic [7:0]            data_byte;
        logic                  last_byte;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
    } plan_entry_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } verdict_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_CHOKED
    } rx_mode_e;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;  // [7:0] data_byte
    logic                  s_axis_tlast  = 1'b0;  // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;        // [31:0] match_offset
    logic                  m_axis_tuser;        // [0] found
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    byte_pattern_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // stimulus plan and predicted verdicts
    plan_entry_t stream_plan [$];
    verdict_t    expected_verdicts [$];

    // transfer seen at the last rising edge, read by the driver
    logic byte_taken = 1'b0;
    logic cfg_taken  = 1'b0;

    // predictor copy of the block state and registers
    logic [7:0]            seen_bytes [PAT_BYTES];
    logic [POS_W-1:0]      scan_position;
    logic                  verdict_sent;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic [START_W-1:0]    start_reg;

    // planning-side view of the current pattern
    logic [7:0] plan_pat [PAT_BYTES];
    int         plan_len;
    int         planned_bytes = 0;
    int         plan_target   = 0;

    int error_count = 0;
    int n_bytes     = 0;
    int n_buffers   = 0;
    int n_found     = 0;
    int n_missed    = 0;
    int n_writes    = 0;

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // does the window hold the first n pattern bytes, oldest byte first
    function automatic logic window_hit(input int n);
        logic [2*CFG_DATA_W-1:0] pat;
        int k;
        pat = {pat_high_reg, pat_low_reg};
        window_hit = 1'b1;
        for (k = 0; k < n; k++)
            if (seen_bytes[n-1-k] != pat[8*k +: 8])
                window_hit = 1'b0;
    endfunction

    // advance the search by one byte; at most one verdict comes out
    task automatic predict_verdict(input logic [7:0] b, input logic last,
                                   output logic produced, output verdict_t v);
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] first;
        int i;
        pos      = scan_position;
        produced = 1'b0;
        v        = '0;
        for (i = PAT_BYTES - 1; i > 0; i--)
            seen_bytes[i] = seen_bytes[i-1];
        seen_bytes[0] = b;

        // a saturated position is never searched
        if (!verdict_sent && pos != {POS_W{1'b1}} && pat_len_reg != 0 &&
            pat_len_reg <= PAT_BYTES) begin
            span = POS_W'(pat_len_reg) - 1'b1;
            if (pos >= span) begin
                first = pos - span;
                if (first >= start_reg && window_hit(int'(pat_len_reg))) begin
                    v.found        = 1'b1;
                    v.match_offset = first[OFFSET_W-1:0];
                    produced       = 1'b1;
                    verdict_sent   = 1'b1;
                end
            end
        end

        if (last) begin
            if (!verdict_sent && !produced) begin
                v        = '0;
                produced = 1'b1;
            end
            scan_position = '0;
            verdict_sent  = 1'b0;
        end else if (pos != {POS_W{1'b1}}) begin
            scan_position = pos + 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: check verdict transfers, predict on byte transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t want;
        verdict_t fresh;
        logic     produced;
        if (!i_rst_n) begin
            foreach (seen_bytes[i]) seen_bytes[i] = '0;
            scan_position = '0;
            verdict_sent  = 1'b0;
            pat_low_reg   = '0;
            pat_high_reg  = '0;
            pat_len_reg   = LEN_RESET;
            start_reg     = '0;
            byte_taken   <= 1'b0;
            cfg_taken    <= 1'b0;
        end else begin
            // the result leaves before its byte's prediction could matter
            if (m_axis_tvalid && m_axis_tready) begin
                got.found        = m_axis_tuser;
                got.match_offset = m_axis_tdata;
                if (got.found === 1'b1) n_found++;
                else n_missed++;
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict found=%b offset=%0d with none pending",
                                              got.found, got.match_offset));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %b, want %b",
                                                  got.found, want.found));
                    if (got.match_offset !== want.match_offset)
                        report_mismatch($sformatf("match offset %0d, want %0d",
                                                  got.match_offset, want.match_offset));
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                predict_verdict(s_axis_tdata, s_axis_tlast, produced, fresh);
                if (produced) expected_verdicts.push_back(fresh);
                n_bytes++;
                if (s_axis_tlast) n_buffers++;
            end

            // register writes land only while the stream is quiet
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PATTERN_LOW:    pat_low_reg  = i_cfg_data;
                    REG_PATTERN_HIGH:   pat_high_reg = i_cfg_data;
                    REG_PATTERN_LENGTH: pat_len_reg  = i_cfg_data[LEN_W-1:0];
                    REG_START_OFFSET:   start_reg    = i_cfg_data[START_W-1:0];
                    default: ;
                endcase
                n_writes++;
            end

            byte_taken <= s_axis_tvalid && s_axis_tready;
            cfg_taken  <= i_cfg_valid && o_cfg_ready;
        end
    end

    // ------------------------------------------------------------------
    // driver: bursts of byte transfers, register writes, quiet points
    // ------------------------------------------------------------------
    int burst_left  = 0;
    int gap_left    = 0;
    int quiet_count = 0;

    always @(negedge i_clk) begin
        logic        sv;
        logic        cv;
        plan_entry_t op;
        sv = s_axis_tvalid;
        cv = i_cfg_valid;
        if (sv && byte_taken) sv = 1'b0;
        if (cv && cfg_taken)  cv = 1'b0;

        if (i_rst_n && !sv && !cv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (stream_plan.size() != 0) begin
                case (stream_plan[0].kind)
                    OP_BYTE: begin
                        op = stream_plan.pop_front();
                        s_axis_tdata <= op.data_byte;
                        s_axis_tlast <= op.last_byte;
                        sv = 1'b1;
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            // a new burst; some follow with no gap at all
                            burst_left = $urandom_range(1, 40);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, 6);
                        end
                    end
                    OP_WRITE: begin
                        op = stream_plan.pop_front();
                        i_cfg_index <= op.reg_index;
                        i_cfg_data  <= op.reg_value;
                        cv = 1'b1;
                    end
                    default: begin
                        // hold off until every verdict is in, then let the pipe empty
                        if (expected_verdicts.size() == 0) begin
                            if (quiet_count >= QUIET_CYCLES) begin
                                void'(stream_plan.pop_front());
                                quiet_count = 0;
                            end else begin
                                quiet_count++;
                            end
                        end
                    end
                endcase
            end
        end
        s_axis_tvalid <= sv;
        i_cfg_valid   <= cv;
    end

    // result side stalls in stretches: open, choppy or nearly shut
    rx_mode_e rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            rx_left = $urandom_range(10, 120);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
            default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // plan building
    // ------------------------------------------------------------------
    task automatic plan_byte(input logic [7:0] b, input logic last);
        plan_entry_t e;
        e           = '0;
        e.kind      = OP_BYTE;
        e.data_byte = b;
        e.last_byte = last;
        stream_plan.push_back(e);
        planned_bytes++;
    endtask

    task automatic plan_write(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
        plan_entry_t e;
        e           = '0;
        e.kind      = OP_WRITE;
        e.reg_index = idx;
        e.reg_value = value;
        stream_plan.push_back(e);
    endtask

    task automatic plan_quiet();
        plan_entry_t e;
        e      = '0;
        e.kind = OP_QUIET;
        stream_plan.push_back(e);
    endtask

    // one buffer: noise, pattern-alphabet bytes, planted copies, damaged copies
    task automatic plan_buffer();
        logic [7:0] frame [$];
        int blen;
        int plen;
        int at;
        int mode;
        int k;
        blen = ($urandom_range(0, 3) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        plen = (plan_len == 0) ? 1 : (plan_len > PAT_BYTES ? PAT_BYTES : plan_len);
        mode = $urandom_range(0, 9);
        for (k = 0; k < blen; k++)
            frame.push_back((mode < 2) ? plan_pat[$urandom_range(0, plen - 1)]
                                       : 8'($urandom_range(0, 255)));
        if (mode >= 5 && blen >= plen) begin
            at = $urandom_range(0, blen - plen);
            for (k = 0; k < plen; k++) frame[at + k] = plan_pat[k];
            if (mode == 9)
                frame[at + $urandom_range(0, plen - 1)] ^= 8'h01 << $urandom_range(0, 7);
            if (mode == 8 && blen >= 2 * plen) begin
                at = $urandom_range(0, blen - plen);
                for (k = 0; k < plen; k++) frame[at + k] = plan_pat[k];
            end
        end
        for (k = 0; k < blen; k++) plan_byte(frame[k], k == blen - 1);
    endtask

    // new register settings, then a handful of buffers; the first byte may
    // follow the last write right away
    task automatic plan_phase();
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] value;
        logic [START_W-1:0]    start;
        logic                  two_symbols;
        int r;
        int k;
        int nbuf;
        r = $urandom_range(0, 9);
        plan_len = (r == 0) ? 0 :
                   (r == 1) ? $urandom_range(PAT_BYTES + 1, 31) :
                   (r == 2) ? PAT_BYTES :
                   (r == 3) ? 1 : $urandom_range(2, PAT_BYTES - 1);
        // a two-symbol pattern gives plenty of overlapping partial matches
        two_symbols = ($urandom_range(0, 2) == 0);
        for (k = 0; k < PAT_BYTES; k++)
            plan_pat[k] = two_symbols ? ($urandom_range(0, 1) ? 8'hAA : 8'h55)
                                      : 8'($urandom_range(0, 255));
        for (k = 0; k < 8; k++) begin
            lo[8*k +: 8] = plan_pat[k];
            hi[8*k +: 8] = plan_pat[k + 8];
        end
        r = $urandom_range(0, 19);
        start = (r < 10) ? '0 :
                (r < 17) ? START_W'($urandom_range(1, 20)) :
                (r < 19) ? START_W'($urandom) : {START_W{1'b1}};

        plan_quiet();
        plan_write(REG_PATTERN_LOW, lo);
        plan_write(REG_PATTERN_HIGH, hi);
        value = {32'($urandom), 32'($urandom)};
        value[LEN_W-1:0] = LEN_W'(plan_len);
        plan_write(REG_PATTERN_LENGTH, value);
        value = {32'($urandom), 32'($urandom)};
        value[START_W-1:0] = start;
        plan_write(REG_START_OFFSET, value);

        nbuf = $urandom_range(2, 8);
        for (k = 0; k < nbuf && planned_bytes < plan_target; k++) plan_buffer();
    endtask

    // ------------------------------------------------------------------
    // reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int k;
        int directed;

        // reset settings: all-zero pattern of length one
        plan_byte(8'h00, 1'b1);
        plan_byte(8'hFF, 1'b0);
        plan_byte(8'h00, 1'b1);

        // full sixteen byte pattern filling a whole buffer
        plan_quiet();
        plan_write(REG_PATTERN_LOW,    64'h7766_5544_3322_1100);
        plan_write(REG_PATTERN_HIGH,   64'hFFEE_DDCC_BBAA_9988);
        plan_write(REG_PATTERN_LENGTH, 64'd16);
        plan_quiet();
        for (k = 0; k < PAT_BYTES; k++) plan_byte(8'(k * 17), k == PAT_BYTES - 1);

        // zero length never matches
        plan_quiet();
        plan_write(REG_PATTERN_LENGTH, 64'd0);
        plan_quiet();
        plan_byte(8'h00, 1'b1);

        // overlong length, written with every data bit set
        plan_quiet();
        plan_write(REG_PATTERN_LENGTH, {CFG_DATA_W{1'b1}});
        plan_quiet();
        plan_byte(8'h00, 1'b0);
        plan_byte(8'h11, 1'b1);

        // search start past the end of the buffer
        plan_quiet();
        plan_write(REG_PATTERN_LENGTH, 64'd1);
        plan_write(REG_START_OFFSET, 64'h0000_0000_FFFF_FFFF);
        plan_quiet();
        plan_byte(8'h00, 1'b0);
        plan_byte(8'h00, 1'b1);

        directed    = planned_bytes;
        plan_target = directed + RANDOM_BYTES;
        while (planned_bytes < plan_target) plan_phase();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stream_plan.size() != 0 || s_axis_tvalid || i_cfg_valid ||
               expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("searched %0d bytes in %0d buffers across %0d register writes",
                 n_bytes, n_buffers, n_writes);
        $display("verdicts: %0d found, %0d not found, %0d mismatches",
                 n_found, n_missed, error_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d verdicts pending, %0d plan entries left",
                 expected_verdicts.size(), stream_plan.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bps_pkg.sv
rtl/bps_cfg.sv
rtl/bps_window.sv
rtl/byte_pattern_search.sv
tb/byte_pattern_search_tb.sv
